// ----- src/pn3d_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pn3d_pkg
// Shared types, permutation table and arithmetic helpers for the 3D noise.
// ---------------------------------------------------------------------------
package pn3d_pkg;

   localparam int CoordWidth = 16;
   localparam int ByteWidth  = 8;

   typedef logic [ByteWidth-1:0]        byte_type;
   typedef logic signed [ByteWidth-1:0] sbyte_type;

   // 257-entry permutation; index 256 repeats entry 0
   function automatic byte_type perm_rom(input logic [8:0] idx);
      byte_type r;
      case (idx[7:0])
         8'd0: r = 8'd151; 8'd1: r = 8'd160; 8'd2: r = 8'd137; 8'd3: r = 8'd91;
         8'd4: r = 8'd90; 8'd5: r = 8'd15; 8'd6: r = 8'd131; 8'd7: r = 8'd13;
         8'd8: r = 8'd201; 8'd9: r = 8'd95; 8'd10: r = 8'd96; 8'd11: r = 8'd53;
         8'd12: r = 8'd194; 8'd13: r = 8'd233; 8'd14: r = 8'd7; 8'd15: r = 8'd225;
         8'd16: r = 8'd140; 8'd17: r = 8'd36; 8'd18: r = 8'd103; 8'd19: r = 8'd30;
         8'd20: r = 8'd69; 8'd21: r = 8'd142; 8'd22: r = 8'd8; 8'd23: r = 8'd99;
         8'd24: r = 8'd37; 8'd25: r = 8'd240; 8'd26: r = 8'd21; 8'd27: r = 8'd10;
         8'd28: r = 8'd23; 8'd29: r = 8'd190; 8'd30: r = 8'd6; 8'd31: r = 8'd148;
         8'd32: r = 8'd247; 8'd33: r = 8'd120; 8'd34: r = 8'd234; 8'd35: r = 8'd75;
         8'd36: r = 8'd0; 8'd37: r = 8'd26; 8'd38: r = 8'd197; 8'd39: r = 8'd62;
         8'd40: r = 8'd94; 8'd41: r = 8'd252; 8'd42: r = 8'd219; 8'd43: r = 8'd203;
         8'd44: r = 8'd117; 8'd45: r = 8'd35; 8'd46: r = 8'd11; 8'd47: r = 8'd32;
         8'd48: r = 8'd57; 8'd49: r = 8'd177; 8'd50: r = 8'd33; 8'd51: r = 8'd88;
         8'd52: r = 8'd237; 8'd53: r = 8'd149; 8'd54: r = 8'd56; 8'd55: r = 8'd87;
         8'd56: r = 8'd174; 8'd57: r = 8'd20; 8'd58: r = 8'd125; 8'd59: r = 8'd136;
         8'd60: r = 8'd171; 8'd61: r = 8'd168; 8'd62: r = 8'd68; 8'd63: r = 8'd175;
         8'd64: r = 8'd74; 8'd65: r = 8'd165; 8'd66: r = 8'd71; 8'd67: r = 8'd134;
         8'd68: r = 8'd139; 8'd69: r = 8'd48; 8'd70: r = 8'd27; 8'd71: r = 8'd166;
         8'd72: r = 8'd77; 8'd73: r = 8'd146; 8'd74: r = 8'd158; 8'd75: r = 8'd231;
         8'd76: r = 8'd83; 8'd77: r = 8'd111; 8'd78: r = 8'd229; 8'd79: r = 8'd122;
         8'd80: r = 8'd60; 8'd81: r = 8'd211; 8'd82: r = 8'd133; 8'd83: r = 8'd230;
         8'd84: r = 8'd220; 8'd85: r = 8'd105; 8'd86: r = 8'd92; 8'd87: r = 8'd41;
         8'd88: r = 8'd55; 8'd89: r = 8'd46; 8'd90: r = 8'd245; 8'd91: r = 8'd40;
         8'd92: r = 8'd244; 8'd93: r = 8'd102; 8'd94: r = 8'd143; 8'd95: r = 8'd54;
         8'd96: r = 8'd65; 8'd97: r = 8'd25; 8'd98: r = 8'd63; 8'd99: r = 8'd161;
         8'd100: r = 8'd1; 8'd101: r = 8'd216; 8'd102: r = 8'd80; 8'd103: r = 8'd73;
         8'd104: r = 8'd209; 8'd105: r = 8'd76; 8'd106: r = 8'd132; 8'd107: r = 8'd187;
         8'd108: r = 8'd208; 8'd109: r = 8'd89; 8'd110: r = 8'd18; 8'd111: r = 8'd169;
         8'd112: r = 8'd200; 8'd113: r = 8'd196; 8'd114: r = 8'd135; 8'd115: r = 8'd130;
         8'd116: r = 8'd116; 8'd117: r = 8'd188; 8'd118: r = 8'd159; 8'd119: r = 8'd86;
         8'd120: r = 8'd164; 8'd121: r = 8'd100; 8'd122: r = 8'd109; 8'd123: r = 8'd198;
         8'd124: r = 8'd173; 8'd125: r = 8'd186; 8'd126: r = 8'd3; 8'd127: r = 8'd64;
         8'd128: r = 8'd52; 8'd129: r = 8'd217; 8'd130: r = 8'd226; 8'd131: r = 8'd250;
         8'd132: r = 8'd124; 8'd133: r = 8'd123; 8'd134: r = 8'd5; 8'd135: r = 8'd202;
         8'd136: r = 8'd38; 8'd137: r = 8'd147; 8'd138: r = 8'd118; 8'd139: r = 8'd126;
         8'd140: r = 8'd255; 8'd141: r = 8'd82; 8'd142: r = 8'd85; 8'd143: r = 8'd212;
         8'd144: r = 8'd207; 8'd145: r = 8'd206; 8'd146: r = 8'd59; 8'd147: r = 8'd227;
         8'd148: r = 8'd47; 8'd149: r = 8'd16; 8'd150: r = 8'd58; 8'd151: r = 8'd17;
         8'd152: r = 8'd182; 8'd153: r = 8'd189; 8'd154: r = 8'd28; 8'd155: r = 8'd42;
         8'd156: r = 8'd223; 8'd157: r = 8'd183; 8'd158: r = 8'd170; 8'd159: r = 8'd213;
         8'd160: r = 8'd119; 8'd161: r = 8'd248; 8'd162: r = 8'd152; 8'd163: r = 8'd2;
         8'd164: r = 8'd44; 8'd165: r = 8'd154; 8'd166: r = 8'd163; 8'd167: r = 8'd70;
         8'd168: r = 8'd221; 8'd169: r = 8'd153; 8'd170: r = 8'd101; 8'd171: r = 8'd155;
         8'd172: r = 8'd167; 8'd173: r = 8'd43; 8'd174: r = 8'd172; 8'd175: r = 8'd9;
         8'd176: r = 8'd129; 8'd177: r = 8'd22; 8'd178: r = 8'd39; 8'd179: r = 8'd253;
         8'd180: r = 8'd19; 8'd181: r = 8'd98; 8'd182: r = 8'd108; 8'd183: r = 8'd110;
         8'd184: r = 8'd79; 8'd185: r = 8'd113; 8'd186: r = 8'd224; 8'd187: r = 8'd232;
         8'd188: r = 8'd178; 8'd189: r = 8'd185; 8'd190: r = 8'd112; 8'd191: r = 8'd104;
         8'd192: r = 8'd218; 8'd193: r = 8'd246; 8'd194: r = 8'd97; 8'd195: r = 8'd228;
         8'd196: r = 8'd251; 8'd197: r = 8'd34; 8'd198: r = 8'd242; 8'd199: r = 8'd193;
         8'd200: r = 8'd238; 8'd201: r = 8'd210; 8'd202: r = 8'd144; 8'd203: r = 8'd12;
         8'd204: r = 8'd191; 8'd205: r = 8'd179; 8'd206: r = 8'd162; 8'd207: r = 8'd241;
         8'd208: r = 8'd81; 8'd209: r = 8'd51; 8'd210: r = 8'd145; 8'd211: r = 8'd235;
         8'd212: r = 8'd249; 8'd213: r = 8'd14; 8'd214: r = 8'd239; 8'd215: r = 8'd107;
         8'd216: r = 8'd49; 8'd217: r = 8'd192; 8'd218: r = 8'd214; 8'd219: r = 8'd31;
         8'd220: r = 8'd181; 8'd221: r = 8'd199; 8'd222: r = 8'd106; 8'd223: r = 8'd157;
         8'd224: r = 8'd184; 8'd225: r = 8'd84; 8'd226: r = 8'd204; 8'd227: r = 8'd176;
         8'd228: r = 8'd115; 8'd229: r = 8'd121; 8'd230: r = 8'd50; 8'd231: r = 8'd45;
         8'd232: r = 8'd127; 8'd233: r = 8'd4; 8'd234: r = 8'd150; 8'd235: r = 8'd254;
         8'd236: r = 8'd138; 8'd237: r = 8'd236; 8'd238: r = 8'd205; 8'd239: r = 8'd93;
         8'd240: r = 8'd222; 8'd241: r = 8'd114; 8'd242: r = 8'd67; 8'd243: r = 8'd29;
         8'd244: r = 8'd24; 8'd245: r = 8'd72; 8'd246: r = 8'd243; 8'd247: r = 8'd141;
         8'd248: r = 8'd128; 8'd249: r = 8'd195; 8'd250: r = 8'd78; 8'd251: r = 8'd66;
         8'd252: r = 8'd215; 8'd253: r = 8'd61; 8'd254: r = 8'd156; 8'd255: r = 8'd180;
         default: r = 8'd0;
      endcase
      // index 256 wraps onto entry 0 (same value)
      return r;
   endfunction

   // (i * (1 + s)) >> 8
   function automatic byte_type scale8(input byte_type i, input byte_type s);
      logic [16:0] p;
      p = {9'd0, i} * {8'd0, {1'b0, s} + 9'd1};
      return p[15:8];
   endfunction

   function automatic byte_type ease_quad(input byte_type i);
      byte_type j;
      byte_type sc;
      byte_type r;
      j = i[7] ? (8'hFF - i) : i;
      sc = scale8(j, j);
      r = {sc[6:0], 1'b0};
      return i[7] ? (8'hFF - r) : r;
   endfunction

   function automatic sbyte_type avg7(input sbyte_type i, input sbyte_type j);
      logic signed [8:0] s;
      s = 9'(i) + 9'(j);
      return sbyte_type'(s[8:1] + {7'd0, i[0]});
   endfunction

   function automatic sbyte_type grad(input byte_type hash, input sbyte_type x,
                                      input sbyte_type y, input sbyte_type z);
      logic [3:0] h;
      sbyte_type u;
      sbyte_type v;
      h = hash[3:0];
      u = h[3] ? y : x;
      if (h < 4'd4)                     v = y;
      else if (h == 4'd12 || h == 4'd14) v = x;
      else                              v = z;
      if (h[0]) u = -u;
      if (h[1]) v = -v;
      return avg7(u, v);
   endfunction

   // a + (b - a) * frac, in the sign-split form
   function automatic sbyte_type lerp7(input sbyte_type a, input sbyte_type b,
                                       input byte_type frac);
      byte_type d;
      if (b > a) begin
         d = byte_type'(b - a);
         return a + sbyte_type'(scale8(d, frac));
      end
      d = byte_type'(a - b);
      return a - sbyte_type'(scale8(d, frac));
   endfunction

   // pipeline stage payload for the hash front end
   typedef struct packed {
      byte_type haa;
      byte_type hab;
      byte_type hba;
      byte_type hbb;
      sbyte_type xx;
      sbyte_type yy;
      sbyte_type zz;
      byte_type eu;
      byte_type ev;
      byte_type ew;
   } hash_type;

   typedef struct packed {
      sbyte_type [7:0] g;
      byte_type eu;
      byte_type ev;
      byte_type ew;
   } grad_type;

endpackage
`default_nettype wire

// ----- src/pn3d_hash.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pn3d_hash
// Stages 1-2: corner hashes through the permutation table, ease curves.
// ---------------------------------------------------------------------------
module pn3d_hash
   import pn3d_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic                  in_valid,
   input  wire logic [CoordWidth-1:0] coord_x,
   input  wire logic [CoordWidth-1:0] coord_y,
   input  wire logic [CoordWidth-1:0] coord_z,
   output logic                       out_valid,
   output hash_type                   out_data
);

   // stage 1: first-level hashes ha, hb
   logic     s1_valid_ff;
   byte_type ha_ff, hb_ff, cz_ff, fx_ff, fy_ff, fz_ff;
   byte_type ha_in, hb_in;

   always_comb begin
      ha_in = perm_rom({1'b0, coord_x[15:8]}) + coord_y[15:8];
      hb_in = perm_rom({1'b0, coord_x[15:8]} + 9'd1) + coord_y[15:8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
      end
      if (advance) begin
         ha_ff <= ha_in;
         hb_ff <= hb_in;
         cz_ff <= coord_z[15:8];
         fx_ff <= coord_x[7:0];
         fy_ff <= coord_y[7:0];
         fz_ff <= coord_z[7:0];
      end
   end

   // stage 2: second-level hashes and ease weights
   logic     s2_valid_ff;
   hash_type s2_ff;
   hash_type s2_in;

   always_comb begin
      s2_in.haa = perm_rom({1'b0, ha_ff}) + cz_ff;
      s2_in.hab = perm_rom({1'b0, ha_ff} + 9'd1) + cz_ff;
      s2_in.hba = perm_rom({1'b0, hb_ff}) + cz_ff;
      s2_in.hbb = perm_rom({1'b0, hb_ff} + 9'd1) + cz_ff;
      s2_in.xx  = sbyte_type'({1'b0, fx_ff[7:1]});
      s2_in.yy  = sbyte_type'({1'b0, fy_ff[7:1]});
      s2_in.zz  = sbyte_type'({1'b0, fz_ff[7:1]});
      s2_in.eu  = ease_quad(fx_ff);
      s2_in.ev  = ease_quad(fy_ff);
      s2_in.ew  = ease_quad(fz_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s2_ff <= s2_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_ff;

endmodule
`default_nettype wire

// ----- src/pn3d_grad.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pn3d_grad
// Stage 3: corner hash lookups and the eight gradient values.
// ---------------------------------------------------------------------------
module pn3d_grad
   import pn3d_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic advance,
   input  wire logic in_valid,
   input  hash_type  in_data,
   output logic      out_valid,
   output grad_type  out_data
);

   logic     valid_ff;
   grad_type data_ff;
   grad_type data_in;
   sbyte_type xm, ym, zm;

   always_comb begin
      // offsets from the far corner: frac/2 - 128
      xm = in_data.xx - 8'sd128;
      ym = in_data.yy - 8'sd128;
      zm = in_data.zz - 8'sd128;
      data_in.g[0] = grad(perm_rom({1'b0, in_data.haa}), in_data.xx, in_data.yy, in_data.zz);
      data_in.g[1] = grad(perm_rom({1'b0, in_data.hba}), xm, in_data.yy, in_data.zz);
      data_in.g[2] = grad(perm_rom({1'b0, in_data.hab}), in_data.xx, ym, in_data.zz);
      data_in.g[3] = grad(perm_rom({1'b0, in_data.hbb}), xm, ym, in_data.zz);
      data_in.g[4] = grad(perm_rom({1'b0, in_data.haa} + 9'd1), in_data.xx, in_data.yy, zm);
      data_in.g[5] = grad(perm_rom({1'b0, in_data.hba} + 9'd1), xm, in_data.yy, zm);
      data_in.g[6] = grad(perm_rom({1'b0, in_data.hab} + 9'd1), in_data.xx, ym, zm);
      data_in.g[7] = grad(perm_rom({1'b0, in_data.hbb} + 9'd1), xm, ym, zm);
      data_in.eu = in_data.eu;
      data_in.ev = in_data.ev;
      data_in.ew = in_data.ew;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

// ----- src/pn3d_blend.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pn3d_blend
// Stages 4-6: x, y and z interpolation, then offset and saturating double.
// ---------------------------------------------------------------------------
module pn3d_blend
   import pn3d_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic advance,
   input  wire logic in_valid,
   input  grad_type  in_data,
   output logic      out_valid,
   output sbyte_type out_raw,
   output byte_type  out_value
);

   // stage 4: x blends
   logic      s4_valid_ff;
   sbyte_type x1_ff, x2_ff, x3_ff, x4_ff;
   byte_type  ev4_ff, ew4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= in_valid;
      end
      if (advance) begin
         x1_ff  <= lerp7(in_data.g[0], in_data.g[1], in_data.eu);
         x2_ff  <= lerp7(in_data.g[2], in_data.g[3], in_data.eu);
         x3_ff  <= lerp7(in_data.g[4], in_data.g[5], in_data.eu);
         x4_ff  <= lerp7(in_data.g[6], in_data.g[7], in_data.eu);
         ev4_ff <= in_data.ev;
         ew4_ff <= in_data.ew;
      end
   end

   // stage 5: y blends
   logic      s5_valid_ff;
   sbyte_type y1_ff, y2_ff;
   byte_type  ew5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s5_valid_ff <= s4_valid_ff;
      end
      if (advance) begin
         y1_ff  <= lerp7(x1_ff, x2_ff, ev4_ff);
         y2_ff  <= lerp7(x3_ff, x4_ff, ev4_ff);
         ew5_ff <= ew4_ff;
      end
   end

   // stage 6: z blend and output mapping
   logic      s6_valid_ff;
   sbyte_type raw_ff;
   byte_type  value_ff;
   sbyte_type raw_in;
   byte_type  off_in;
   byte_type  value_in;

   always_comb begin
      raw_in   = lerp7(y1_ff, y2_ff, ew5_ff);
      off_in   = byte_type'(raw_in) + 8'd64;
      value_in = off_in[7] ? 8'hFF : {off_in[6:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (advance) begin
         s6_valid_ff <= s5_valid_ff;
      end
      if (advance) begin
         raw_ff   <= raw_in;
         value_ff <= value_in;
      end
   end

   assign out_valid = s6_valid_ff;
   assign out_raw   = raw_ff;
   assign out_value = value_ff;

endmodule
`default_nettype wire

// ----- src/perlin_noise_3d_8bit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// perlin_noise_3d_8bit
// 8-bit 3D gradient noise, one sample per clock while the output is not stalled.
// ---------------------------------------------------------------------------
// Input channel req_*: coordinates with req_valid / req_stall; a transfer
// happens when req_valid is high and req_stall low. Output channel rsp_*:
// noise_raw and noise_value with rsp_valid / rsp_stall.
// Six register stages: two hash stages, gradient lookup, then x, y and z
// blends. Throughput is one sample per clock while no result is held
// stalled. When the receiver stalls with a result held, the whole
// pipeline freezes, empty stages included, and req_stall rises in the
// same cycle; nothing moves until the held result transfers.
// Synchronous reset clears all valid bits; the data registers are not reset.
// ---------------------------------------------------------------------------
module perlin_noise_3d_8bit
   import pn3d_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [CoordWidth-1:0] req_coord_x,
   input  wire logic [CoordWidth-1:0] req_coord_y,
   input  wire logic [CoordWidth-1:0] req_coord_z,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic signed [ByteWidth-1:0] rsp_noise_raw,
   output logic [ByteWidth-1:0]       rsp_noise_value
);

   logic     advance;
   logic     hash_valid, grad_valid;
   hash_type hash_data;
   grad_type grad_data;

   // global enable: move when the output slot is empty or being taken
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   pn3d_hash u_hash (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .coord_x   (req_coord_x),
      .coord_y   (req_coord_y),
      .coord_z   (req_coord_z),
      .out_valid (hash_valid),
      .out_data  (hash_data)
   );

   pn3d_grad u_grad (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (hash_valid),
      .in_data   (hash_data),
      .out_valid (grad_valid),
      .out_data  (grad_data)
   );

   pn3d_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (grad_valid),
      .in_data   (grad_data),
      .out_valid (rsp_valid),
      .out_raw   (rsp_noise_raw),
      .out_value (rsp_noise_value)
   );

endmodule
`default_nettype wire

// ----- src/perlin_noise_3d_8bit_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pn3d_checker
// Port-level checks on the noise block, bound to the top level.
// ---------------------------------------------------------------------------
module pn3d_checker
   import pn3d_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_stall,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic [ByteWidth-1:0]  rsp_noise_raw,
   input wire logic [ByteWidth-1:0]  rsp_noise_value
);

   // a held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_noise_raw)
                                 && $stable(rsp_noise_value))
      else $error("rsp payload changed while stalled");

   // intake is blocked only while a result waits
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall without output backpressure");

   // value is the offset-and-double map of raw
   a_value_map: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_noise_value == (((rsp_noise_raw + 8'd64) & 8'h80) != 8'd0
                    ? 8'hFF : {rsp_noise_raw[6:0] + 7'd64, 1'b0}))
      else $error("noise_value inconsistent with noise_raw");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("rsp_valid right after reset");

endmodule

bind perlin_noise_3d_8bit pn3d_checker u_pn3d_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_noise_raw   (rsp_noise_raw),
   .rsp_noise_value (rsp_noise_value)
);
`default_nettype wire
